[hdl/rrb_pkg.sv]
package rrb_pkg;

  localparam int DEPTH_W = 24;
  localparam int STORE_W = 32;
  localparam int EXP_BITS = 20;

  localparam logic [2:0] CFG_ICAP   = 3'd0;
  localparam logic [2:0] CFG_ICOEFF = 3'd1;
  localparam logic [2:0] CFG_ISHAPE = 3'd2;
  localparam logic [2:0] CFG_SCAP   = 3'd3;
  localparam logic [2:0] CFG_FLOW   = 3'd4;
  localparam logic [2:0] CFG_ITHR   = 3'd5;
  localparam logic [2:0] CFG_SETLIM = 3'd6;
  localparam logic [2:0] CFG_INIT   = 3'd7;

  typedef struct packed {
    logic [DEPTH_W-1:0] rainfall;
    logic [DEPTH_W-1:0] pet;
    logic               series_start;
  } in_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] total_runoff;
    logic [DEPTH_W-1:0] total_et;
    logic [DEPTH_W-1:0] impervious_runoff;
    logic [DEPTH_W-1:0] interception_et;
    logic [DEPTH_W-1:0] infiltration_excess;
    logic [DEPTH_W-1:0] infiltration_amount;
    logic [DEPTH_W-1:0] interflow;
    logic [DEPTH_W-1:0] recharge_amount;
    logic [DEPTH_W-1:0] soil_et;
    logic [DEPTH_W-1:0] baseflow_out;
    logic [STORE_W-1:0] soil_level;
    logic [STORE_W-1:0] groundwater_level;
  } out_item_t;

  // exp(-2^(b-16)) in Q0.32, b = 0..19
  function automatic logic [32*EXP_BITS-1:0] exp_table_f();
    logic [63:0] t;
    logic [63:0] acc;
    logic [63:0] tab;
    logic [32*EXP_BITS-1:0] res;
    int k;
    res = '0;
    tab = '0;
    for (int b = 0; b < EXP_BITS; b++) begin
      if (b <= 16) begin
        k = 16 - b;
        t = 64'h1_0000_0000;
        acc = t;
        for (int n = 1; n < 48; n++) begin
          t = (t >> k) / 64'(n);
          if ((n % 2) == 1) acc = acc - t;
          else acc = acc + t;
        end
        tab = acc;
      end else begin
        tab = (tab * tab + 64'h8000_0000) >> 32;
      end
      res[b*32 +: 32] = tab[31:0];
    end
    return res;
  endfunction

endpackage

[hdl/rainfall_runoff_bucket_step_top.sv]
// The work is a 16-step restoring divider (run up to twice) and a 20-step exponential, all
// over one shared 33x33 multiply-add unit. The second divide is skipped when the soil store
// overflows, the first when the soil is full on entry; series start goes straight to the
// result. A new item is accepted only when idle; result stalls hold the finished item.
// A finished item waits in the output register while the next one is worked on.
// Reset (synchronous, rst_n low): stores cleared, registers to defaults, no item held.
module rainfall_runoff_bucket_step_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rrb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rrb_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import rrb_pkg::*;

  localparam logic [32*EXP_BITS-1:0] EXP_TAB = exp_table_f();

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIVI = 5'd1;
  localparam logic [4:0] S_DIV  = 5'd2;
  localparam logic [4:0] S_MX   = 5'd3;
  localparam logic [4:0] S_EXP  = 5'd4;
  localparam logic [4:0] S_MINF = 5'd5;
  localparam logic [4:0] S_M1   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_M3   = 5'd8;
  localparam logic [4:0] S_M4   = 5'd9;
  localparam logic [4:0] S_UPD  = 5'd10;
  localparam logic [4:0] S_MBF  = 5'd11;
  localparam logic [4:0] S_MSL  = 5'd12;
  localparam logic [4:0] S_SET  = 5'd13;
  localparam logic [4:0] S_T1   = 5'd14;
  localparam logic [4:0] S_T2   = 5'd15;
  localparam logic [4:0] S_T3   = 5'd16;
  localparam logic [4:0] S_T4   = 5'd17;
  localparam logic [4:0] S_DONE = 5'd18;

  localparam logic [65:0] RND31 = 66'h8000_0000;
  localparam logic [65:0] RND15 = 66'h8000;
  localparam logic [65:0] RND11 = 66'h800;
  localparam logic [16:0] ONE16 = 17'h1_0000;

  // configuration
  logic [23:0] icap_r, icoeff_r, scap_r, ithr_r, setlim_r;
  logic [15:0] ishape_r;
  logic [63:0] flow_r, init_r;

  // control
  logic [4:0]  state_r;
  logic [3:0]  cnt_r;
  logic [4:0]  bit_r;
  logic        div_sel_r;
  logic        e_one_r;
  logic        zero_r;
  logic        out_valid_r;

  // stores and working values
  logic [31:0] soil_r, gw_r, s_r, g_r, bf_r;
  logic [23:0] rain_r, pet_r, rem_r, infcap_r, ifl_r, rch_r, limt_r, set_r;
  logic [23:0] tet_r, tro_r, bfo_r;
  logic [16:0] q_r;
  logic [19:0] x_r;
  logic [31:0] e_r;
  logic [32:0] t_r;
  logic [49:0] acc_r;
  out_item_t   out_r;

  // shared multiply-add
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_c, mul_p;

  logic [23:0] cap_eff, imp_et, imp_ro, int_et, thru, inf_w, xs_w, after_w, petr_w;
  logic [23:0] ci, cr, m1_w, set_w;
  logic [15:0] cb, pf;
  logic [16:0] pfc;
  logic [31:0] tab_w;
  logic [24:0] rem2;
  logic        ge;
  logic [32:0] s_sum;
  logic [33:0] g_sum, g_tot;
  logic        ovf;
  logic        out_free;

  assign cap_eff = (scap_r == '0) ? 24'd1 : scap_r;
  assign ci  = {8'd0, flow_r[15:0]};
  assign cr  = {8'd0, flow_r[31:16]};
  assign cb  = flow_r[47:32];
  assign pf  = flow_r[63:48];
  assign pfc = ONE16 - {1'b0, pf};

  assign imp_et = (ithr_r < rain_r) ? ithr_r : rain_r;
  assign imp_ro = rain_r - imp_et;
  assign int_et = (rain_r < ((pet_r < icap_r) ? pet_r : icap_r)) ? rain_r :
                  ((pet_r < icap_r) ? pet_r : icap_r);
  assign thru    = rain_r - int_et;
  assign inf_w   = (thru < infcap_r) ? thru : infcap_r;
  assign xs_w    = thru - inf_w;
  assign after_w = inf_w - ifl_r;
  assign petr_w  = pet_r - int_et;
  assign m1_w    = (petr_w < limt_r) ? petr_w : limt_r;
  assign set_w   = (s_r < {8'd0, m1_w}) ? s_r[23:0] : m1_w;

  assign tab_w = EXP_TAB[{bit_r, 5'd0} +: 32];

  assign rem2 = {rem_r, 1'b0};
  assign ge   = rem2 >= {1'b0, cap_eff};

  assign s_sum = {1'b0, soil_r} + {9'd0, after_w} - {9'd0, rch_r};
  assign g_sum = {2'd0, gw_r} + {10'd0, rch_r};
  assign ovf   = s_sum > {9'd0, cap_eff};
  assign g_tot = ovf ? (g_sum + {1'b0, s_sum - {9'd0, cap_eff}}) : g_sum;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_c = '0;
    case (state_r)
      S_MX: begin
        mul_a = {17'd0, ishape_r};
        mul_b = {16'd0, q_r};
        mul_c = RND11;
      end
      S_EXP: begin
        mul_a = {1'b0, e_r};
        mul_b = {1'b0, tab_w};
        mul_c = RND31;
      end
      S_MINF: begin
        mul_a = {9'd0, icoeff_r};
        mul_b = {1'b0, e_r};
        mul_c = RND31;
      end
      S_M1: begin
        mul_a = {9'd0, ci};
        mul_b = {16'd0, q_r};
      end
      S_M2: begin
        mul_a = t_r;
        mul_b = {9'd0, inf_w};
        mul_c = RND31;
      end
      S_M3: begin
        mul_a = {9'd0, cr};
        mul_b = {16'd0, q_r};
      end
      S_M4: begin
        mul_a = t_r;
        mul_b = {9'd0, after_w};
        mul_c = RND31;
      end
      S_MBF: begin
        mul_a = {1'b0, g_r};
        mul_b = {17'd0, cb};
        mul_c = RND15;
      end
      S_MSL: begin
        mul_a = {16'd0, q_r};
        mul_b = {9'd0, setlim_r};
        mul_c = RND15;
      end
      S_SET: begin
        mul_a = {16'd0, pfc};
        mul_b = {9'd0, imp_et};
      end
      S_T1: begin
        mul_a = {17'd0, pf};
        mul_b = {9'd0, int_et} + {9'd0, set_r};
        mul_c = {16'd0, acc_r} + RND15;
      end
      S_T2: begin
        mul_a = {16'd0, pfc};
        mul_b = {9'd0, imp_ro};
      end
      S_T3: begin
        mul_a = {17'd0, pf};
        mul_b = {9'd0, xs_w} + {9'd0, ifl_r} + {1'b0, bf_r};
        mul_c = {16'd0, acc_r} + RND15;
      end
      S_T4: begin
        mul_a = {1'b0, bf_r};
        mul_b = {17'd0, pf};
        mul_c = RND15;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign mul_p = ({33'd0, mul_a} * {33'd0, mul_b}) + mul_c;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icap_r   <= 24'd384;
      icoeff_r <= 24'd51200;
      ishape_r <= 16'd12288;
      scap_r   <= 24'd25600;
      flow_r   <= '0;
      ithr_r   <= 24'd256;
      setlim_r <= 24'd2560;
      init_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ICAP:   icap_r   <= cfg_data[23:0];
        CFG_ICOEFF: icoeff_r <= cfg_data[23:0];
        CFG_ISHAPE: ishape_r <= cfg_data[15:0];
        CFG_SCAP:   scap_r   <= cfg_data[23:0];
        CFG_FLOW:   flow_r   <= cfg_data;
        CFG_ITHR:   ithr_r   <= cfg_data[23:0];
        CFG_SETLIM: setlim_r <= cfg_data[23:0];
        CFG_INIT:   init_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      soil_r      <= '0;
      gw_r        <= '0;
      out_valid_r <= 1'b0;
      zero_r      <= 1'b0;
      div_sel_r   <= 1'b0;
      e_one_r     <= 1'b1;
      cnt_r       <= '0;
      bit_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            rain_r <= in_data.rainfall;
            pet_r  <= in_data.pet;
            if (in_data.series_start) begin
              s_r     <= init_r[31:0];
              g_r     <= init_r[63:32];
              zero_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              zero_r    <= 1'b0;
              div_sel_r <= 1'b0;
              rem_r     <= (soil_r < {8'd0, cap_eff}) ? soil_r[23:0] : cap_eff;
              state_r   <= S_DIVI;
            end
          end
        end
        S_DIVI: begin
          cnt_r <= '0;
          if (rem_r == cap_eff) begin
            q_r     <= ONE16;
            state_r <= div_sel_r ? S_MBF : S_MX;
          end else begin
            q_r     <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= ge ? (rem2[23:0] - cap_eff) : rem2[23:0];
          q_r   <= {q_r[15:0], ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) state_r <= div_sel_r ? S_MBF : S_MX;
        end
        S_MX: begin
          x_r     <= mul_p[31:12];
          bit_r   <= '0;
          e_one_r <= 1'b1;
          state_r <= S_EXP;
        end
        S_EXP: begin
          if (x_r[bit_r]) begin
            e_one_r <= 1'b0;
            e_r     <= e_one_r ? tab_w : mul_p[63:32];
          end
          if (bit_r == 5'(EXP_BITS - 1)) state_r <= S_MINF;
          else bit_r <= bit_r + 5'd1;
        end
        S_MINF: begin
          infcap_r <= e_one_r ? icoeff_r : mul_p[55:32];
          state_r  <= S_M1;
        end
        S_M1: begin
          t_r     <= mul_p[32:0];
          state_r <= S_M2;
        end
        S_M2: begin
          ifl_r   <= mul_p[55:32];
          state_r <= S_M3;
        end
        S_M3: begin
          t_r     <= mul_p[32:0];
          state_r <= S_M4;
        end
        S_M4: begin
          rch_r   <= mul_p[55:32];
          state_r <= S_UPD;
        end
        S_UPD: begin
          g_r <= (g_tot[33:32] != 2'd0) ? 32'hFFFF_FFFF : g_tot[31:0];
          if (ovf) begin
            s_r     <= {8'd0, cap_eff};
            q_r     <= ONE16;
            state_r <= S_MBF;
          end else begin
            s_r       <= s_sum[31:0];
            rem_r     <= s_sum[23:0];
            div_sel_r <= 1'b1;
            state_r   <= S_DIVI;
          end
        end
        S_MBF: begin
          bf_r    <= mul_p[47:16];
          state_r <= S_MSL;
        end
        S_MSL: begin
          limt_r  <= mul_p[39:16];
          g_r     <= g_r - bf_r;
          state_r <= S_SET;
        end
        S_SET: begin
          set_r   <= set_w;
          s_r     <= s_r - {8'd0, set_w};
          acc_r   <= mul_p[49:0];
          state_r <= S_T1;
        end
        S_T1: begin
          tet_r   <= (mul_p[65:40] != '0) ? 24'hFF_FFFF : mul_p[39:16];
          state_r <= S_T2;
        end
        S_T2: begin
          acc_r   <= mul_p[49:0];
          state_r <= S_T3;
        end
        S_T3: begin
          tro_r   <= (mul_p[65:40] != '0) ? 24'hFF_FFFF : mul_p[39:16];
          state_r <= S_T4;
        end
        S_T4: begin
          bfo_r   <= (mul_p[65:40] != '0) ? 24'hFF_FFFF : mul_p[39:16];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            soil_r      <= s_r;
            gw_r        <= g_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_r.soil_level        <= s_r;
      out_r.groundwater_level <= g_r;
      if (zero_r) begin
        out_r.total_runoff        <= '0;
        out_r.total_et            <= '0;
        out_r.impervious_runoff   <= '0;
        out_r.interception_et     <= '0;
        out_r.infiltration_excess <= '0;
        out_r.infiltration_amount <= '0;
        out_r.interflow           <= '0;
        out_r.recharge_amount     <= '0;
        out_r.soil_et             <= '0;
        out_r.baseflow_out        <= '0;
      end else begin
        out_r.total_runoff        <= tro_r;
        out_r.total_et            <= tet_r;
        out_r.impervious_runoff   <= imp_ro;
        out_r.interception_et     <= int_et;
        out_r.infiltration_excess <= xs_w;
        out_r.infiltration_amount <= inf_w;
        out_r.interflow           <= ifl_r;
        out_r.recharge_amount     <= rch_r;
        out_r.soil_et             <= set_r;
        out_r.baseflow_out        <= bfo_r;
      end
    end
  end

endmodule
